// File: hdl/pfp_pkg.sv
// ----------------------------------------------------------------------------
// pfp_pkg
// Types and constants shared by the plane-from-three-points pipeline.
// ----------------------------------------------------------------------------
package pfp_pkg;

    localparam int NORM_FRAC  = 30;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 31;
    localparam int SQRT_FIRST = 7;
    localparam int DIV_FIRST  = SQRT_FIRST + SQRT_STEPS + 1;
    localparam int MUL_STAGE  = DIV_FIRST + DIV_STEPS + 1;
    localparam int STAGES     = MUL_STAGE + 2;

    typedef struct packed {
        logic [2:0][31:0] p1;
        logic [2:0]       neg;
        logic             sh_s;
        logic [5:0]       sh_t;
        logic [2:0][30:0] mag;
        logic             degen;
    } side_t;

endpackage

// File: hdl/plane_from_three_points.sv
// ----------------------------------------------------------------------------
// plane_from_three_points
// Unit normal (Q1.30) and plane offset (Q18.16) of the plane through three
// Q16.16 points, with a degenerate flag for short normals.
// ----------------------------------------------------------------------------
// One item per cycle; results pass through 74 register stages, most of them in
// the 32-stage integer square root and the 31-stage restoring divider (three
// lanes) that follow the cross product; stalls at the output fill empty stages
// first, then hold the input.
module plane_from_three_points (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [62:0]  cfg_wr_data,    // degenerate_limit
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z,
    // third_x, third_y, third_z
    input  logic [287:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // normal_x, normal_y, normal_z, plane_offset, zero pad
    output logic [135:0] m_axis_tdata,
    output logic [0:0]   m_axis_tuser    // degenerate
);
    import pfp_pkg::*;

    logic [62:0]        limit_reg;
    logic [STAGES-1:0]  en;
    logic [STAGES-1:0]  vld;

    side_t              side_reg  [STAGES];
    side_t              side_next [STAGES];

    logic signed [32:0] d_reg  [6];
    logic signed [32:0] d_next [6];
    logic signed [31:0] ab_reg  [6];
    logic signed [31:0] ab_next [6];
    logic               s_next;
    logic signed [63:0] pr_reg  [6];
    logic signed [63:0] pr_next [6];
    logic signed [63:0] c_reg  [3];
    logic signed [63:0] c_next [3];
    logic [62:0]        cm_reg  [3];
    logic [62:0]        cm_next [3];
    logic [2:0]         neg_next;
    logic [62:0]        orv;
    logic [6:0]         blen;
    logic [5:0]         t_next;
    logic [2:0][30:0]   m_next;
    logic [61:0]        sq_reg  [3];
    logic [61:0]        sq_next [3];
    logic [63:0]        sqx_reg  [SQRT_STEPS+1];
    logic [63:0]        sqx_next [SQRT_STEPS+1];
    logic [63:0]        sqr_reg  [SQRT_STEPS+1];
    logic [63:0]        sqr_next [SQRT_STEPS+1];
    logic [31:0]        dq_reg  [DIV_STEPS+1];
    logic [31:0]        dq_next [DIV_STEPS+1];
    logic [31:0]        dvr_reg  [DIV_STEPS+1][3];
    logic [31:0]        dvr_next [DIV_STEPS+1][3];
    logic [30:0]        dvn_reg  [DIV_STEPS+1][3];
    logic [30:0]        dvn_next [DIV_STEPS+1][3];
    logic [31:0]        q_root;
    logic [5:0]         e_sh;
    logic [66:0]        q_scaled;
    logic               degen_next;
    logic [61:0]        num [3];
    logic [30:0]        qt_reg [3];
    logic signed [63:0] np_reg  [3];
    logic signed [63:0] np_next [3];
    logic signed [63:0] dot;
    logic [31:0]        nrm [3];
    logic [135:0]       tdata_next;
    logic [135:0]       tdata_reg;
    logic               tuser_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= 63'd1;
        else if (cfg_wr_en)
            limit_reg <= cfg_wr_data;
    end

    pfp_pipe_ctl #(
        .STAGES(STAGES)
    ) u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .out_ready (m_axis_tready),
        .en        (en),
        .vld       (vld)
    );

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = vld[STAGES-1];

    // edge vectors
    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            d_next[i] = {s_axis_tdata[32*(i+3)+31], s_axis_tdata[32*(i+3) +: 32]}
                      - {s_axis_tdata[32*(i%3)+31], s_axis_tdata[32*(i%3) +: 32]};
        end
    end

    // common scale so edges fit 32 bits signed
    always_comb
    begin
        logic [32:0] mg [6];
        logic [31:0] sh;
        s_next = 1'b0;
        for (int i = 0; i < 6; i++)
        begin
            mg[i] = d_reg[i][32] ? 33'(-d_reg[i]) : d_reg[i];
            s_next = s_next | mg[i][31] | mg[i][32];
        end
        for (int i = 0; i < 6; i++)
        begin
            sh = s_next ? mg[i][32:1] : mg[i][31:0];
            ab_next[i] = d_reg[i][32] ? -$signed(sh) : $signed(sh);
        end
    end

    always_comb
    begin
        pr_next[0] = ab_reg[1] * ab_reg[5];
        pr_next[1] = ab_reg[2] * ab_reg[4];
        pr_next[2] = ab_reg[2] * ab_reg[3];
        pr_next[3] = ab_reg[0] * ab_reg[5];
        pr_next[4] = ab_reg[0] * ab_reg[4];
        pr_next[5] = ab_reg[1] * ab_reg[3];
        for (int i = 0; i < 3; i++)
        begin
            c_next[i]   = pr_reg[2*i] - pr_reg[2*i+1];
            neg_next[i] = c_reg[i][63];
            cm_next[i]  = c_reg[i][63] ? 63'(-c_reg[i]) : c_reg[i][62:0];
        end
    end

    // normalize cross product to 31 bits
    always_comb
    begin
        orv  = cm_reg[0] | cm_reg[1] | cm_reg[2];
        blen = '0;
        for (int b = 0; b < 63; b++)
        begin
            if (orv[b])
                blen = 7'(b + 1);
        end
        t_next = (blen > 7'd31) ? 6'(blen - 7'd31) : 6'd0;
        for (int i = 0; i < 3; i++)
        begin
            m_next[i]  = 31'(cm_reg[i] >> t_next);
            sq_next[i] = 62'(side_reg[5].mag[i]) * 62'(side_reg[5].mag[i]);
        end
    end

    // integer square root, one result bit per stage
    always_comb
    begin
        logic [63:0] bt;
        sqx_next[0] = 64'(sq_reg[0]) + 64'(sq_reg[1]) + 64'(sq_reg[2]);
        sqr_next[0] = '0;
        for (int j = 0; j < SQRT_STEPS; j++)
        begin
            bt = 64'd1 << (62 - 2*j);
            if (sqx_reg[j] >= sqr_reg[j] + bt)
            begin
                sqx_next[j+1] = sqx_reg[j] - (sqr_reg[j] + bt);
                sqr_next[j+1] = (sqr_reg[j] >> 1) + bt;
            end
            else
            begin
                sqx_next[j+1] = sqx_reg[j];
                sqr_next[j+1] = sqr_reg[j] >> 1;
            end
        end
    end

    // degenerate test and divider setup
    always_comb
    begin
        logic [32:0] tt;
        logic        ge;
        q_root     = sqr_reg[SQRT_STEPS][31:0];
        e_sh       = {4'd0, side_reg[DIV_FIRST-1].sh_s, 1'b0} + side_reg[DIV_FIRST-1].sh_t;
        q_scaled   = 67'(q_root) << e_sh;
        degen_next = (q_root == '0) || (q_scaled < 67'(limit_reg));
        dq_next[0] = q_root;
        for (int i = 0; i < 3; i++)
        begin
            num[i] = {side_reg[DIV_FIRST-1].mag[i], 31'd0} >> 1;
            num[i] = num[i] + 62'(q_root >> 1);
            dvr_next[0][i] = 32'(num[i][61:31]);
            dvn_next[0][i] = num[i][30:0];
        end
        // restoring division, one quotient bit per stage
        for (int j = 1; j <= DIV_STEPS; j++)
        begin
            dq_next[j] = dq_reg[j-1];
            for (int i = 0; i < 3; i++)
            begin
                tt = {dvr_reg[j-1][i], dvn_reg[j-1][i][30]};
                ge = tt >= {1'b0, dq_reg[j-1]};
                dvr_next[j][i] = ge ? 32'(tt - {1'b0, dq_reg[j-1]}) : tt[31:0];
                dvn_next[j][i] = {dvn_reg[j-1][i][29:0], ge};
            end
        end
    end

    // plane offset
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            np_next[i] = $signed({1'b0, dvn_reg[DIV_STEPS][i]})
                       * $signed(side_reg[MUL_STAGE-1].p1[i]);
        end
        dot = 64'sd1 <<< (NORM_FRAC - 1);
        for (int i = 0; i < 3; i++)
        begin
            dot  = dot + (side_reg[MUL_STAGE].neg[i] ? -np_reg[i] : np_reg[i]);
            nrm[i] = side_reg[MUL_STAGE].neg[i] ? 32'(-{1'b0, qt_reg[i]})
                                               : {1'b0, qt_reg[i]};
        end
        if (side_reg[MUL_STAGE].degen)
            tdata_next = '0;
        else
            tdata_next = {6'd0, dot[63:NORM_FRAC], nrm[2], nrm[1], nrm[0]};
    end

    always_comb
    begin
        side_next[0] = '0;
        for (int i = 0; i < 3; i++)
            side_next[0].p1[i] = s_axis_tdata[32*i +: 32];
        for (int k = 1; k < STAGES; k++)
            side_next[k] = side_reg[k-1];
        side_next[1].sh_s        = s_next;
        side_next[4].neg         = neg_next;
        side_next[5].sh_t        = t_next;
        side_next[5].mag         = m_next;
        side_next[DIV_FIRST].degen = degen_next;
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < STAGES; k++)
        begin
            if (en[k])
                side_reg[k] <= side_next[k];
        end
        if (en[0])
            d_reg <= d_next;
        if (en[1])
            ab_reg <= ab_next;
        if (en[2])
            pr_reg <= pr_next;
        if (en[3])
            c_reg <= c_next;
        if (en[4])
            cm_reg <= cm_next;
        if (en[6])
            sq_reg <= sq_next;
        for (int j = 0; j <= SQRT_STEPS; j++)
        begin
            if (en[SQRT_FIRST+j])
            begin
                sqx_reg[j] <= sqx_next[j];
                sqr_reg[j] <= sqr_next[j];
            end
        end
        for (int j = 0; j <= DIV_STEPS; j++)
        begin
            if (en[DIV_FIRST+j])
            begin
                dq_reg[j]  <= dq_next[j];
                dvr_reg[j] <= dvr_next[j];
                dvn_reg[j] <= dvn_next[j];
            end
        end
        if (en[MUL_STAGE])
        begin
            np_reg <= np_next;
            qt_reg <= dvn_reg[DIV_STEPS];
        end
        if (en[STAGES-1])
        begin
            tdata_reg <= tdata_next;
            tuser_reg <= side_reg[MUL_STAGE].degen;
        end
    end

    assign m_axis_tdata = tdata_reg;
    assign m_axis_tuser = tuser_reg;

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("degenerate result carries nonzero data");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |->
            $signed(m_axis_tdata[31:0]) <= 32'sd1073741824 &&
            $signed(m_axis_tdata[31:0]) >= -32'sd1073741824)
        else $error("normal x out of unit range");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !vld[0] |-> s_axis_tready)
        else $error("empty first stage refuses an item");

endmodule

// File: hdl/pfp_pipe_ctl.sv
// ----------------------------------------------------------------------------
// pfp_pipe_ctl
// Valid bits and per-stage enables; a stage loads when empty or draining.
// ----------------------------------------------------------------------------
module pfp_pipe_ctl #(
    parameter int STAGES = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              out_ready,
    output logic [STAGES-1:0] en,
    output logic [STAGES-1:0] vld
);

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;
    logic [STAGES:0]   rdy;

    always_comb
    begin
        rdy[STAGES] = out_ready;
        for (int k = STAGES - 1; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        en = rdy[STAGES-1:0];
        for (int k = 0; k < STAGES; k++)
        begin
            if (k == 0)
                vld_next[k] = en[k] ? in_valid : vld_reg[k];
            else
                vld_next[k] = en[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign vld = vld_reg;

endmodule
